// File: hw/rtl/rdia_pkg.sv
// Package of shared types and constants for the ring discovery id assigner.
`default_nettype none
package rdia_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TTL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_TYPE_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ADDRESS   = 2'd2;

	localparam logic [3:0] INITIAL_TTL_RESET = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_CHK,
		ST_SORT_LDV,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMPTY
	} state_t;

	typedef enum logic [1:0] {
		I_HOLD,
		I_ONE,
		I_ZERO,
		I_INC
	} i_op_t;

	typedef enum logic {
		RD_I,
		RD_JM1
	} rd_sel_t;

	typedef enum logic {
		WR_SHIFT,
		WR_V
	} wr_sel_t;

	typedef struct packed {
		logic    in_ready;
		logic    store_pkt;
		logic    clr_count;
		i_op_t   i_op;
		logic    j_load_i;
		logic    j_dec;
		logic    v_load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    out_load_entry;
		logic    out_load_empty;
	} rdia_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_kind;
		logic count_zero;
		logic i_at_count;
		logic j_zero;
		logic greater;
		logic out_free;
		logic last_entry;
	} rdia_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/rdia_pkt_if.sv
// Stream interface for received packet items.
`default_nettype none
interface rdia_pkt_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] packet_type;
	logic [7:0] dest_address;
	logic [3:0] ttl_left;

	modport source (output valid, kind, packet_type, dest_address, ttl_left, input ready);
	modport sink (input valid, kind, packet_type, dest_address, ttl_left, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rdia_route_if.sv
// Stream interface for route entry results.
`default_nettype none
interface rdia_route_if;
	logic       valid;
	logic       ready;
	logic [5:0] nodes_found;
	logic       entry_valid;
	logic [5:0] node_id;
	logic [7:0] hop_position;
	logic       last;

	modport source (output valid, nodes_found, entry_valid, node_id, hop_position, last,
		input ready);
	modport sink (input valid, nodes_found, entry_valid, node_id, hop_position, last,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rdia_cfg_if.sv
// Write channel interface for the configuration registers.
`default_nettype none
interface rdia_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rdia_pkg::CFG_IDX_W-1:0]  index;
	logic [rdia_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rdia_ctrl.sv
// Controller state machine: collection, in-place insertion sort and route emission.
`default_nettype none
module rdia_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rdia_pkg::rdia_sts_t sts,
	output rdia_pkg::rdia_cmd_t      cmd
);

	rdia_pkg::state_t state_q;
	rdia_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdia_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		cmd.in_ready       = 1'b0;
		cmd.store_pkt      = 1'b0;
		cmd.clr_count      = 1'b0;
		cmd.i_op           = rdia_pkg::I_HOLD;
		cmd.j_load_i       = 1'b0;
		cmd.j_dec          = 1'b0;
		cmd.v_load         = 1'b0;
		cmd.rd_en          = 1'b0;
		cmd.rd_sel         = rdia_pkg::RD_I;
		cmd.wr_en          = 1'b0;
		cmd.wr_sel         = rdia_pkg::WR_V;
		cmd.out_load_entry = 1'b0;
		cmd.out_load_empty = 1'b0;
		case (state_q)
			rdia_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					if (!sts.in_kind) begin
						cmd.store_pkt = 1'b1;
					end else if (sts.count_zero) begin
						state_d = rdia_pkg::ST_EMPTY;
					end else begin
						cmd.i_op = rdia_pkg::I_ONE;
						state_d  = rdia_pkg::ST_SORT_CHK;
					end
				end
			end
			rdia_pkg::ST_SORT_CHK: begin
				if (sts.i_at_count) begin
					cmd.i_op = rdia_pkg::I_ZERO;
					state_d  = rdia_pkg::ST_EMIT_RD;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = rdia_pkg::RD_I;
					cmd.j_load_i = 1'b1;
					state_d      = rdia_pkg::ST_SORT_LDV;
				end
			end
			rdia_pkg::ST_SORT_LDV: begin
				cmd.v_load = 1'b1;
				state_d    = rdia_pkg::ST_SORT_RD;
			end
			rdia_pkg::ST_SORT_RD: begin
				if (sts.j_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = rdia_pkg::WR_V;
					cmd.i_op   = rdia_pkg::I_INC;
					state_d    = rdia_pkg::ST_SORT_CHK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rdia_pkg::RD_JM1;
					state_d    = rdia_pkg::ST_SORT_CMP;
				end
			end
			rdia_pkg::ST_SORT_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.greater) begin
					cmd.wr_sel = rdia_pkg::WR_SHIFT;
					cmd.j_dec  = 1'b1;
					state_d    = rdia_pkg::ST_SORT_RD;
				end else begin
					cmd.wr_sel = rdia_pkg::WR_V;
					cmd.i_op   = rdia_pkg::I_INC;
					state_d    = rdia_pkg::ST_SORT_CHK;
				end
			end
			rdia_pkg::ST_EMIT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rdia_pkg::RD_I;
				state_d    = rdia_pkg::ST_EMIT_LD;
			end
			rdia_pkg::ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load_entry = 1'b1;
					if (sts.last_entry) begin
						cmd.clr_count = 1'b1;
						state_d       = rdia_pkg::ST_IDLE;
					end else begin
						cmd.i_op = rdia_pkg::I_INC;
						state_d  = rdia_pkg::ST_EMIT_RD;
					end
				end
			end
			rdia_pkg::ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_load_empty = 1'b1;
					state_d            = rdia_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdia_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/rdia_datapath.sv
// Datapath: configuration registers, position memory, sort indexes and output register.
`default_nettype none
module rdia_datapath #(
	parameter int unsigned MAX_NODES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	rdia_pkt_if.sink                 pkt,
	rdia_route_if.source             route,
	rdia_cfg_if.sink                 cfg,
	input  wire rdia_pkg::rdia_cmd_t cmd,
	output rdia_pkg::rdia_sts_t      sts
);

	localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
	localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	logic [3:0] initial_ttl_q;
	logic [7:0] status_type_code_q;
	logic [7:0] master_address_q;

	logic [7:0]       mem [MAX_NODES];
	logic [7:0]       rd_data_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [7:0]       v_q;

	logic             out_valid_q;
	logic [5:0]       out_nodes_found_q;
	logic             out_entry_valid_q;
	logic [5:0]       out_node_id_q;
	logic [7:0]       out_hop_position_q;
	logic             out_last_q;

	logic [CNT_W-1:0] jm1;
	logic [CNT_W:0]   id_next;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             pkt_match;
	logic             pkt_store;
	logic [7:0]       hop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_ttl_q      <= rdia_pkg::INITIAL_TTL_RESET;
			status_type_code_q <= '0;
			master_address_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rdia_pkg::CFG_INITIAL_TTL:      initial_ttl_q      <= cfg.data[3:0];
				rdia_pkg::CFG_STATUS_TYPE_CODE: status_type_code_q <= cfg.data;
				rdia_pkg::CFG_MASTER_ADDRESS:   master_address_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Hop position wraps modulo 256 when the remaining TTL exceeds the start value.
	assign hop       = {4'd0, initial_ttl_q} - {4'd0, pkt.ttl_left};
	assign pkt_match = (pkt.packet_type == status_type_code_q) &&
		(pkt.dest_address == master_address_q);
	assign pkt_store = cmd.store_pkt && pkt_match && (count_q < CNT_W'(MAX_NODES));

	assign jm1     = j_q - CNT_W'(1);
	assign id_next = {1'b0, i_q} + (CNT_W + 1)'(1);
	assign rd_addr = (cmd.rd_sel == rdia_pkg::RD_JM1) ? jm1[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign wr_addr = pkt_store ? count_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign wr_data = pkt_store ? hop :
		((cmd.wr_sel == rdia_pkg::WR_SHIFT) ? rd_data_q : v_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_en || pkt_store) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.v_load) begin
			v_q <= rd_data_q;
		end
		if (cmd.j_load_i) begin
			j_q <= i_q;
		end else if (cmd.j_dec) begin
			j_q <= jm1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q     <= '0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (pkt_store) begin
				count_q <= count_q + CNT_W'(1);
			end
			case (cmd.i_op)
				rdia_pkg::I_ONE:  i_q <= CNT_W'(1);
				rdia_pkg::I_ZERO: i_q <= '0;
				rdia_pkg::I_INC:  i_q <= id_next[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_entry || cmd.out_load_empty) begin
			out_valid_q <= 1'b1;
		end else if (route.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_entry) begin
			out_nodes_found_q  <= 6'(count_q);
			out_entry_valid_q  <= 1'b1;
			out_node_id_q      <= 6'(id_next);
			out_hop_position_q <= rd_data_q;
			out_last_q         <= (id_next == {1'b0, count_q});
		end else if (cmd.out_load_empty) begin
			out_nodes_found_q  <= '0;
			out_entry_valid_q  <= 1'b0;
			out_node_id_q      <= '0;
			out_hop_position_q <= '0;
			out_last_q         <= 1'b1;
		end
	end

	assign pkt.ready          = cmd.in_ready;
	assign route.valid        = out_valid_q;
	assign route.nodes_found  = out_nodes_found_q;
	assign route.entry_valid  = out_entry_valid_q;
	assign route.node_id      = out_node_id_q;
	assign route.hop_position = out_hop_position_q;
	assign route.last         = out_last_q;

	assign sts.in_valid   = pkt.valid;
	assign sts.in_kind    = pkt.kind;
	assign sts.count_zero = (count_q == '0);
	assign sts.i_at_count = (i_q == count_q);
	assign sts.j_zero     = (j_q == '0);
	assign sts.greater    = (rd_data_q > v_q);
	assign sts.out_free   = !out_valid_q || route.ready;
	assign sts.last_entry = (id_next == {1'b0, count_q});

endmodule
`default_nettype wire

// File: hw/rtl/ring_discovery_id_assigner.sv
// Top level of the ring discovery id assigner: controller joined to its datapath.
// Usage: the pkt channel carries one item per transfer. An item with kind 0 is a
// received packet header; it is stored as a hop position when its type matches the
// configured status code, its destination matches the master address and the table
// holds fewer than MAX_NODES positions. A header gives no result.
// An item with kind 1 ends the window: the stored positions are sorted in place by
// an insertion sort on the single position memory, then one route transfer per node
// leaves on the route channel in ascending order with ids 1..n, the last one marked.
// A window with no nodes gives one empty result with last set.
// The sort is paced by the one read and one write port of the memory; emission reads
// each entry, then loads it into the output register once that is free.
// The cfg channel is always ready; writes take effect at the transfer edge and are
// to be made only while the block is idle, which the block itself does not enforce.
// An index past the register list is ignored.
// When the receiver stalls, the result is held in the output register and the
// sequencer waits. After the last result is loaded, pkt is ready again even if that
// result has not been taken yet.
// Reset (arst_n low) empties the table, clears the output valid flag and sets
// initial_ttl to 15, status_type_code and master_address to 0. No clearing pass.
`default_nettype none
module ring_discovery_id_assigner #(
	parameter int unsigned MAX_NODES = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rdia_pkt_if.sink     pkt,
	rdia_route_if.source route,
	rdia_cfg_if.sink     cfg
);

	// Commands from the sequencer and status back from the datapath.
	rdia_pkg::rdia_cmd_t cmd;
	rdia_pkg::rdia_sts_t sts;

	rdia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// The datapath owns the position memory, the sort indexes and the output stage.
	rdia_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.route  (route),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
`default_nettype wire
